// ----- rtl/core/cna_pkg.sv -----
// Shared types and constants of the complex number arithmetic unit.
`default_nettype none

package cna_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int IO_BITS       = 32;
    localparam int MID_DEPTH     = 4;
    localparam int OUT_DEPTH     = 2;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        kind_t                      kind;
        logic signed [IO_BITS-1:0]  a_real;
        logic signed [IO_BITS-1:0]  a_imag;
        logic signed [IO_BITS-1:0]  b_real;
        logic signed [IO_BITS-1:0]  b_imag;
    } in_word_t;

    typedef struct packed {
        logic signed [IO_BITS-1:0]  res_real;
        logic signed [IO_BITS-1:0]  res_imag;
        status_t                    status;
    } out_word_t;

    // Classified operation: operands already sign-extended from the word width.
    typedef struct packed {
        kind_t                      kind;
        logic                       div_zero;
        logic signed [IO_BITS-1:0]  ar;
        logic signed [IO_BITS-1:0]  ai;
        logic signed [IO_BITS-1:0]  br;
        logic signed [IO_BITS-1:0]  bi;
    } op_word_t;

endpackage

`default_nettype wire

// ----- rtl/core/complex_number_alu_unit.sv -----
// Top level of the complex number arithmetic unit.
`default_nettype none

// Complex add, subtract, multiply and divide on signed fixed point parts.
// Input channel: present a word on in_word and raise push; the word is taken
// at a rising edge where push is high and full is low. The word carries the
// operation kind and the two operands A and B.
// Result channel: while empty is low the oldest result word sits on out_word;
// it is taken at a rising edge where pop is high and empty is low.
// A front stage narrows the operands to WORD_BITS and flags division by zero,
// then hands the word through a four-entry queue to the back pipeline. The
// back pipeline forms the products in one stage, the exact sums in the next,
// then runs a restoring long division with one quotient bit per stage
// (WORD_BITS stages plus an overflow check), and saturates into a two-entry
// output queue. One word is taken every cycle while the receiver keeps popping.
// When the receiver stops popping, the output queue fills, the back pipeline
// holds, the middle queue fills and full rises; no word is lost.
// Reset clears all queues and valid flags; the data registers are not reset.
module complex_number_alu_unit
    import cna_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_word_t in_word,
    input  wire logic     push,
    output logic          full,
    output out_word_t     out_word,
    output logic          empty,
    input  wire logic     pop
);

    op_word_t  fr_word, bk_word;
    logic      fr_push, mid_full, mid_empty, bk_pop;
    out_word_t res_word;
    logic      res_push, res_full;

    // Front stage: classification.
    cna_front #(.WORD_BITS(WORD_BITS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_word (in_word),
        .push    (push),
        .full    (full),
        .op_word (fr_word),
        .op_push (fr_push),
        .op_full (mid_full)
    );

    // The middle queue lets the front keep taking words while the back holds.
    cna_queue #(.WIDTH($bits(op_word_t)), .DEPTH(MID_DEPTH)) u_mid_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fr_push),
        .full     (mid_full),
        .data_in  (fr_word),
        .pop      (bk_pop),
        .empty    (mid_empty),
        .data_out (bk_word)
    );

    cna_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_word  (bk_word),
        .op_empty (mid_empty),
        .op_pop   (bk_pop),
        .res_word (res_word),
        .res_push (res_push),
        .res_full (res_full)
    );

    // The output queue is the result register and buffers results while the receiver stalls.
    cna_queue #(.WIDTH($bits(out_word_t)), .DEPTH(OUT_DEPTH)) u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .full     (res_full),
        .data_in  (res_word),
        .pop      (pop),
        .empty    (empty),
        .data_out (out_word)
    );

    localparam logic signed [IO_BITS-1:0] SAT_MAX = IO_BITS'((64'sd1 <<< (WORD_BITS - 1)) - 1);
    localparam logic signed [IO_BITS-1:0] SAT_MIN = IO_BITS'(-(64'sd1 <<< (WORD_BITS - 1)));

`ifndef NO_ASSERTIONS
    a_div_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_word.status == STATUS_DIV_ZERO)
            |-> (out_word.res_real == '0 && out_word.res_imag == '0))
        else $error("division by zero result is not zero");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_word.status != 2'd3))
        else $error("undefined status code on result");

    a_overflow_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_word.status == STATUS_OVERFLOW)
            |-> (out_word.res_real == SAT_MAX || out_word.res_real == SAT_MIN
                 || out_word.res_imag == SAT_MAX || out_word.res_imag == SAT_MIN))
        else $error("overflow status without a saturated part");

    a_full_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> mid_full)
        else $error("input stalled while middle queue has room");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/cna_queue.sv -----
// Small first-word-fall-through queue used between the parts of the unit.
`default_nettype none

module cna_queue
    import cna_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [WIDTH-1:0] data_in,
    input  wire logic             pop,
    output logic                  empty,
    output logic      [WIDTH-1:0] data_out
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNTW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cna_front.sv -----
// Front part: accepts input words, narrows the operands and flags division by zero.
`default_nettype none

module cna_front
    import cna_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_word_t in_word,
    input  wire logic     push,
    output logic          full,
    output op_word_t      op_word,
    output logic          op_push,
    input  wire logic     op_full
);

    logic     valid_reg;
    op_word_t word_reg, word_next;

    function automatic logic signed [IO_BITS-1:0] narrow(input logic [IO_BITS-1:0] x);
        logic signed [WORD_BITS-1:0] t;
        t = x[WORD_BITS-1:0];
        return IO_BITS'(t);
    endfunction

    always_comb
    begin
        word_next.kind     = in_word.kind;
        word_next.ar       = narrow(in_word.a_real);
        word_next.ai       = narrow(in_word.a_imag);
        word_next.br       = narrow(in_word.b_real);
        word_next.bi       = narrow(in_word.b_imag);
        word_next.div_zero = (in_word.kind == KIND_DIV)
                             && (in_word.b_real[WORD_BITS-1:0] == '0)
                             && (in_word.b_imag[WORD_BITS-1:0] == '0);
    end

    assign full    = valid_reg && op_full;
    assign op_push = valid_reg;
    assign op_word = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!full)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!full)
        begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cna_back.sv -----
// Back part: product, sum, long division and saturation pipeline.
`default_nettype none

module cna_back
    import cna_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire op_word_t op_word,
    input  wire logic     op_empty,
    output logic          op_pop,
    output out_word_t     res_word,
    output logic          res_push,
    input  wire logic     res_full
);

    localparam int W  = WORD_BITS;
    localparam int MW = 2 * W + 1;
    localparam int CW = 3 * W + FRAC_BITS + 2;
    localparam int NS = W;

    logic en;
    assign en     = !res_full;
    assign op_pop = en && !op_empty;

    // Stage 1: partial products.
    logic                  s1_valid_reg;
    kind_t                 s1_kind_reg;
    logic                  s1_dz_reg;
    logic signed [W-1:0]   s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;
    logic signed [2*W-1:0] s1_prr_reg, s1_pii_reg, s1_pri_reg, s1_pir_reg;
    logic signed [2*W-1:0] s1_pbr_reg, s1_pbi_reg;
    logic signed [W-1:0]   ar, ai, br, bi;

    assign ar = op_word.ar[W-1:0];
    assign ai = op_word.ai[W-1:0];
    assign br = op_word.br[W-1:0];
    assign bi = op_word.bi[W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_kind_reg <= op_word.kind;
            s1_dz_reg   <= op_word.div_zero;
            s1_ar_reg   <= ar;
            s1_ai_reg   <= ai;
            s1_br_reg   <= br;
            s1_bi_reg   <= bi;
            s1_prr_reg  <= ar * br;
            s1_pii_reg  <= ai * bi;
            s1_pri_reg  <= ar * bi;
            s1_pir_reg  <= ai * br;
            s1_pbr_reg  <= br * br;
            s1_pbi_reg  <= bi * bi;
        end
    end

    // Stage 2: exact sums as sign and magnitude, and the divisor norm.
    logic signed [MW-1:0] sr, si;
    logic                 nr_next, ni_next;
    logic [MW-1:0]        mr_next, mi_next, den_next;

    always_comb
    begin
        case (s1_kind_reg)
            KIND_ADD:
            begin
                sr = MW'(s1_ar_reg) + MW'(s1_br_reg);
                si = MW'(s1_ai_reg) + MW'(s1_bi_reg);
            end
            KIND_SUB:
            begin
                sr = MW'(s1_ar_reg) - MW'(s1_br_reg);
                si = MW'(s1_ai_reg) - MW'(s1_bi_reg);
            end
            KIND_MUL:
            begin
                sr = MW'(s1_prr_reg) - MW'(s1_pii_reg);
                si = MW'(s1_pri_reg) + MW'(s1_pir_reg);
            end
            default:
            begin
                sr = MW'(s1_prr_reg) + MW'(s1_pii_reg);
                si = MW'(s1_pir_reg) - MW'(s1_pri_reg);
            end
        endcase
        nr_next  = sr[MW-1];
        ni_next  = si[MW-1];
        mr_next  = nr_next ? MW'(-sr) : MW'(sr);
        mi_next  = ni_next ? MW'(-si) : MW'(si);
        if (s1_kind_reg == KIND_MUL)
        begin
            mr_next = mr_next >> FRAC_BITS;
            mi_next = mi_next >> FRAC_BITS;
        end
        den_next = MW'($unsigned(s1_pbr_reg)) + MW'($unsigned(s1_pbi_reg));
    end

    logic          s2_valid_reg;
    kind_t         s2_kind_reg;
    logic          s2_dz_reg, s2_nr_reg, s2_ni_reg;
    logic [MW-1:0] s2_mr_reg, s2_mi_reg, s2_den_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_dz_reg   <= s1_dz_reg;
            s2_nr_reg   <= nr_next;
            s2_ni_reg   <= ni_next;
            s2_mr_reg   <= mr_next;
            s2_mi_reg   <= mi_next;
            s2_den_reg  <= den_next;
        end
    end

    // Division stages: index 0 holds the overflow check, each later one a quotient bit.
    logic          d_valid_reg [0:NS];
    kind_t         d_kind_reg  [0:NS];
    logic          d_dz_reg    [0:NS];
    logic          d_nr_reg    [0:NS];
    logic          d_ni_reg    [0:NS];
    logic [MW-1:0] d_mr_reg    [0:NS];
    logic [MW-1:0] d_mi_reg    [0:NS];
    logic [MW-1:0] d_den_reg   [0:NS];
    logic [CW-1:0] d_rr_reg    [0:NS];
    logic [CW-1:0] d_ri_reg    [0:NS];
    logic [W-1:0]  d_qr_reg    [0:NS];
    logic [W-1:0]  d_qi_reg    [0:NS];
    logic          d_or_reg    [0:NS];
    logic          d_oi_reg    [0:NS];

    logic [CW-1:0] rr0, ri0, dsh0;
    assign rr0  = CW'(s2_mr_reg) << FRAC_BITS;
    assign ri0  = CW'(s2_mi_reg) << FRAC_BITS;
    assign dsh0 = CW'(s2_den_reg) << W;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_kind_reg[0] <= s2_kind_reg;
            d_dz_reg[0]   <= s2_dz_reg;
            d_nr_reg[0]   <= s2_nr_reg;
            d_ni_reg[0]   <= s2_ni_reg;
            d_mr_reg[0]   <= s2_mr_reg;
            d_mi_reg[0]   <= s2_mi_reg;
            d_den_reg[0]  <= s2_den_reg;
            d_rr_reg[0]   <= rr0;
            d_ri_reg[0]   <= ri0;
            d_qr_reg[0]   <= '0;
            d_qi_reg[0]   <= '0;
            d_or_reg[0]   <= (rr0 >= dsh0);
            d_oi_reg[0]   <= (ri0 >= dsh0);
        end
    end

    for (genvar j = 1; j <= NS; j++)
    begin : g_div
        logic [CW-1:0] dsh;
        logic          tr, ti;
        assign dsh = CW'(d_den_reg[j-1]) << (W - j);
        assign tr  = (d_rr_reg[j-1] >= dsh);
        assign ti  = (d_ri_reg[j-1] >= dsh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_kind_reg[j] <= d_kind_reg[j-1];
                d_dz_reg[j]   <= d_dz_reg[j-1];
                d_nr_reg[j]   <= d_nr_reg[j-1];
                d_ni_reg[j]   <= d_ni_reg[j-1];
                d_mr_reg[j]   <= d_mr_reg[j-1];
                d_mi_reg[j]   <= d_mi_reg[j-1];
                d_den_reg[j]  <= d_den_reg[j-1];
                d_or_reg[j]   <= d_or_reg[j-1];
                d_oi_reg[j]   <= d_oi_reg[j-1];
                d_rr_reg[j]   <= tr ? d_rr_reg[j-1] - dsh : d_rr_reg[j-1];
                d_ri_reg[j]   <= ti ? d_ri_reg[j-1] - dsh : d_ri_reg[j-1];
                d_qr_reg[j]   <= d_qr_reg[j-1] | (tr ? W'(1) << (W - j) : '0);
                d_qi_reg[j]   <= d_qi_reg[j-1] | (ti ? W'(1) << (W - j) : '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int k = 0; k <= NS; k++)
            begin
                d_valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_valid_reg   <= !op_empty;
            s2_valid_reg   <= s1_valid_reg;
            d_valid_reg[0] <= s2_valid_reg;
            for (int k = 1; k <= NS; k++)
            begin
                d_valid_reg[k] <= d_valid_reg[k-1];
            end
        end
    end

    // Final stage: pick the magnitude, saturate and pack the result word.
    localparam logic [MW-1:0] HALF = MW'(1) << (W - 1);

    function automatic logic signed [IO_BITS-1:0] sat(input logic neg, input logic [MW-1:0] mag,
                                                      output logic ovf);
        logic signed [W-1:0] v;
        ovf = 1'b0;
        if (neg)
        begin
            if (mag > HALF)
            begin
                ovf = 1'b1;
                v   = W'(HALF);
            end
            else
            begin
                v = W'(-mag);
            end
        end
        else
        begin
            if (mag > HALF - 1'b1)
            begin
                ovf = 1'b1;
                v   = W'(HALF - 1'b1);
            end
            else
            begin
                v = W'(mag);
            end
        end
        return IO_BITS'(v);
    endfunction

    logic [MW-1:0] fr, fi;
    logic          ovr, ovi;

    always_comb
    begin
        if (d_kind_reg[NS] == KIND_DIV)
        begin
            fr = d_or_reg[NS] ? MW'(1) << W : MW'(d_qr_reg[NS]);
            fi = d_oi_reg[NS] ? MW'(1) << W : MW'(d_qi_reg[NS]);
        end
        else
        begin
            fr = d_mr_reg[NS];
            fi = d_mi_reg[NS];
        end
        res_word.res_real = sat(d_nr_reg[NS], fr, ovr);
        res_word.res_imag = sat(d_ni_reg[NS], fi, ovi);
        res_word.status   = (ovr || ovi) ? STATUS_OVERFLOW : STATUS_OK;
        if (d_dz_reg[NS])
        begin
            res_word.res_real = '0;
            res_word.res_imag = '0;
            res_word.status   = STATUS_DIV_ZERO;
        end
    end

    assign res_push = en && d_valid_reg[NS];

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the complex number arithmetic unit.
`default_nettype none

module tb_top;
    import cna_pkg::*;

    // Idle cycles with no accepted word, in either direction, before the run is abandoned.
    localparam int STALL_LIMIT = 4000;
    // Accept-to-output latency of the block at the default width, plus margin.
    localparam int DRAIN_CYCLES = 80;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    in_word_t  in_word = '0;
    logic      push = 1'b0;
    logic      full;
    out_word_t out_word;
    logic      empty;
    logic      pop = 1'b0;

    // Outputs are sampled on the falling edge, half a period away from any change.
    logic      full_seen = 1'b1;
    logic      empty_seen = 1'b1;
    out_word_t out_seen;

    out_word_t expected_results[$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    logic      word_moved = 1'b0;

    complex_number_alu_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_word),
        .push     (push),
        .full     (full),
        .out_word (out_word),
        .empty    (empty),
        .pop      (pop)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
    begin
        full_seen  <= full;
        empty_seen <= empty;
        out_seen   <= out_word;
    end

    // Saturate one result part given as sign and magnitude to a 32-bit word.
    function automatic logic [31:0] clamp_part(input logic neg, input logic [127:0] mag,
                                               inout logic ovf);
        logic [31:0] part;
        if (neg)
        begin
            if (mag > 128'h8000_0000)
            begin
                ovf  = 1'b1;
                part = 32'h8000_0000;
            end
            else
            begin
                part = -mag[31:0];
            end
        end
        else if (mag > 128'h7fff_ffff)
        begin
            ovf  = 1'b1;
            part = 32'h7fff_ffff;
        end
        else
        begin
            part = mag[31:0];
        end
        return part;
    endfunction

    // Exact complex arithmetic in wide integers, then one truncation toward zero
    // and saturation of each part.
    function automatic out_word_t compute_complex(input in_word_t w);
        logic signed [127:0] ar, ai, br, bi, sum_re, sum_im;
        logic [127:0]        mag_re, mag_im, den;
        logic                neg_re, neg_im, ovf;
        out_word_t           r;
        ar  = w.a_real;
        ai  = w.a_imag;
        br  = w.b_real;
        bi  = w.b_imag;
        ovf = 1'b0;
        den = br * br + bi * bi;
        case (w.kind)
            KIND_ADD:
            begin
                sum_re = ar + br;
                sum_im = ai + bi;
            end
            KIND_SUB:
            begin
                sum_re = ar - br;
                sum_im = ai - bi;
            end
            KIND_MUL:
            begin
                sum_re = ar * br - ai * bi;
                sum_im = ar * bi + ai * br;
            end
            default:
            begin
                sum_re = ar * br + ai * bi;
                sum_im = br * ai - ar * bi;
            end
        endcase
        neg_re = sum_re < 0;
        neg_im = sum_im < 0;
        mag_re = neg_re ? -sum_re : sum_re;
        mag_im = neg_im ? -sum_im : sum_im;
        if (w.kind == KIND_MUL)
        begin
            mag_re = mag_re >> FRAC_BITS_DEF;
            mag_im = mag_im >> FRAC_BITS_DEF;
        end
        else if (w.kind == KIND_DIV)
        begin
            // A zero divisor gives a zero result with its own status.
            if (den == 0)
            begin
                r.res_real = '0;
                r.res_imag = '0;
                r.status   = STATUS_DIV_ZERO;
                return r;
            end
            mag_re = (mag_re << FRAC_BITS_DEF) / den;
            mag_im = (mag_im << FRAC_BITS_DEF) / den;
        end
        r.res_real = clamp_part(neg_re, mag_re, ovf);
        r.res_imag = clamp_part(neg_im, mag_im, ovf);
        r.status   = ovf ? STATUS_OVERFLOW : STATUS_OK;
        return r;
    endfunction

    // Offer one word, idling first at the current sender rate. Push stays high
    // afterwards, so back-to-back words keep push high with no gap between them.
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        in_word <= w;
        push    <= 1'b1;
        @(negedge clk);
        while (full !== 1'b0)
            @(negedge clk);
        @(posedge clk);
        expected_results.push_back(compute_complex(w));
    endtask

    task automatic finish_sending();
        push <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: takes the word on the output when pop was high and empty was
    // low, compares it with the oldest prediction, and picks the next pop.
    always @(posedge clk)
    begin
        out_word_t want;
        word_moved = 1'b0;
        if (rst_n && pop && !empty_seen)
        begin
            word_moved = 1'b1;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: %h", out_seen);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_seen.res_real !== want.res_real || out_seen.res_imag !== want.res_imag
                    || out_seen.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
                                 want.res_real, want.res_imag, want.status,
                                 out_seen.res_real, out_seen.res_imag, out_seen.status);
                end
            end
        end
        pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: any accepted word on either side restarts the count.
    always @(posedge clk)
    begin
        if (word_moved || (push && !full_seen))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("** complex_number_alu_unit: FAILED **");
            $finish;
        end
    end

    function automatic logic [31:0] pick_part();
        logic [31:0] extremes[5];
        extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff};
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom;
            2: return 32'($signed($urandom_range(0, 32'h1f_ffff)) - 32'sh10_0000);
            3: return extremes[$urandom_range(4)];
            default: return 32'h0;
        endcase
    endfunction

    function automatic in_word_t make_word(input kind_t k, input logic [31:0] ar,
                                           input logic [31:0] ai, input logic [31:0] br,
                                           input logic [31:0] bi);
        in_word_t w;
        w.kind   = k;
        w.a_real = ar;
        w.a_imag = ai;
        w.b_real = br;
        w.b_imag = bi;
        return w;
    endfunction

    // Corner cases: every operation, field extremes, overflow, zero divisor,
    // truncation of negative products and quotients.
    task automatic test_directed();
        send_word(make_word(KIND_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hfffe_0000));
        send_word(make_word(KIND_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        send_word(make_word(KIND_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
        send_word(make_word(KIND_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
        send_word(make_word(KIND_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h0000_0001));
        send_word(make_word(KIND_SUB, 32'hffff_ffff, 32'h1234_5678, 32'hffff_ffff, 32'h1234_5678));
        send_word(make_word(KIND_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hffff_0000));
        send_word(make_word(KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_word(make_word(KIND_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
        send_word(make_word(KIND_MUL, 32'hffff_ffff, 32'h0, 32'h0000_0001, 32'h0));
        send_word(make_word(KIND_MUL, 32'hffff_8001, 32'h0000_7fff, 32'h0000_0003, 32'hffff_fffd));
        send_word(make_word(KIND_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0));
        send_word(make_word(KIND_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0));
        send_word(make_word(KIND_DIV, 32'h0005_0000, 32'hfffd_0000, 32'h0001_0000, 32'h0));
        send_word(make_word(KIND_DIV, 32'h0001_0000, 32'h0, 32'h0000_0001, 32'h0));
        send_word(make_word(KIND_DIV, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'hffff_ffff));
        send_word(make_word(KIND_DIV, 32'hffff_ffff, 32'h0, 32'h0003_0000, 32'h0));
        send_word(make_word(KIND_DIV, 32'h0001_0000, 32'h0002_0000, 32'h7fff_ffff, 32'h8000_0000));
        send_word(make_word(KIND_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_word(make_word(KIND_DIV, 32'h0, 32'h0, 32'h0002_0000, 32'h0003_0000));
        finish_sending();
    endtask

    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
            send_word(make_word(kind_t'($urandom_range(3)), pick_part(), pick_part(),
                                pick_part(), pick_part()));
        finish_sending();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(470, 35, 73);
        test_random(470, 73, 35);
        test_random(460, 0, 0);
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("** complex_number_alu_unit: PASSED **");
        else
            $display("** complex_number_alu_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
